/* hw/rtl/double_header_frame_receiver_assert.svh */
// Assertion macros for the checker file of the frame receiver.
`ifndef DOUBLE_HEADER_FRAME_RECEIVER_ASSERT_SVH
`define DOUBLE_HEADER_FRAME_RECEIVER_ASSERT_SVH

// Assertion that is switched off while reset is high.
`define DHFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that also holds while reset is high.
`define DHFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/dhfr_pkg.sv */
// Types and constants shared by the double header frame receiver modules.
package dhfr_pkg;

  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 4;

  localparam logic [BYTE_W-1:0]  HEADER_RESET = 8'd85;
  localparam logic [BYTE_W-1:0]  MIN_LEN      = 8'd2;
  localparam logic [BYTE_W-1:0]  MAX_LEN      = 8'd8;
  localparam logic [INDEX_W-1:0] LEN_RESET    = 4'd2;

  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef struct packed {
    logic accept;
    logic load_out;
    logic next_idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit_go;
    logic emit_done;
    logic out_free;
  } dp_status_t;

endpackage

/* hw/rtl/double_header_frame_receiver.sv */
// Top level of the double header frame receiver.
// The receiver takes one transaction per cycle on the item channel while item_stall is
// low: a received byte (command 0) or a release of the pending frame (command 1).
// It looks for two header bytes in a row, takes the next byte as the frame length L
// (2 to 8, otherwise the frame is dropped) and collects bytes until the frame holds
// L+2 bytes. A completed frame with no earlier frame pending is marked pending and
// sent out as L+2 result transactions, the first carrying the header byte and the
// final one flagged last; further completed frames are dropped until a release. An
// item that completes an emitted frame holds the item channel after it is accepted,
// also while the result side stalls, because the sequencer reads the frame store
// through its single registered read port and steps through a read state and a load
// state for each frame byte. Every other item is taken without holding the channel.
// The header byte register is written through the configuration channel, which is
// always ready, and resets to 0x55. The frame store needs no clearing pass.
module double_header_frame_receiver #(
  parameter int STORE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       command,
  input  logic [7:0] rx_byte,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] frame_byte,
  output logic [3:0] byte_index,
  output logic       last
);

  import dhfr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  dhfr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  dhfr_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .command      (command),
    .rx_byte      (rx_byte),
    .cmd          (cmd),
    .status       (status),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .frame_byte   (frame_byte),
    .byte_index   (byte_index),
    .last         (last)
  );

endmodule

/* hw/rtl/dhfr_ram.sv */
// Generic single write port RAM with one registered read port.
module dhfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/dhfr_ctrl.sv */
// Controller state machine that sequences byte intake and frame output.
module dhfr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  dhfr_pkg::dp_status_t status,
  output dhfr_pkg::ctrl_cmd_t  cmd
);

  import dhfr_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = 1'b1;
    case (state)
      S_IDLE: begin
        item_stall = 1'b0;
        cmd.accept = item_valid;
        if (item_valid && status.emit_go) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          if (status.emit_done) begin
            state_next = S_IDLE;
          end else begin
            cmd.next_idx = 1'b1;
            state_next   = S_READ;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hw/rtl/dhfr_datapath.sv */
// Datapath with the parser state, the frame store and the result register.
module dhfr_datapath #(
  parameter int STORE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [7:0]           cfg_data,
  input  logic                 command,
  input  logic [7:0]           rx_byte,
  input  dhfr_pkg::ctrl_cmd_t  cmd,
  output dhfr_pkg::dp_status_t status,
  input  logic                 result_stall,
  output logic                 result_valid,
  output logic [7:0]           frame_byte,
  output logic [3:0]           byte_index,
  output logic                 last
);

  import dhfr_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  logic [BYTE_W-1:0]  header_byte;
  logic               in_frame;
  logic               one_header_seen;
  logic [INDEX_W-1:0] frame_length;
  logic [INDEX_W-1:0] byte_count;
  logic               frame_pending;
  logic [INDEX_W-1:0] idx;

  logic               hit;
  logic               frm_eff;
  logic               one_next;
  logic [INDEX_W-1:0] bc_eff;
  logic               len_chk;
  logic               bad_len;
  logic [INDEX_W-1:0] len_next;
  logic               frm_kept;
  logic [INDEX_W-1:0] bc_inc;
  logic               done;
  logic               is_byte;
  logic               wr_en;
  logic [BYTE_W-1:0]  rd_data;
  logic [INDEX_W-1:0] last_idx;

  always_comb begin
    hit      = (rx_byte == header_byte);
    frm_eff  = in_frame;
    one_next = one_header_seen;
    bc_eff   = byte_count;
    if (!in_frame) begin
      if (hit) begin
        if (one_header_seen) begin
          one_next = 1'b0;
          frm_eff  = 1'b1;
          bc_eff   = 4'd1;
        end else begin
          one_next = 1'b1;
        end
      end else begin
        one_next = 1'b0;
        bc_eff   = 4'd0;
      end
    end
    len_chk  = frm_eff && (bc_eff == 4'd2);
    bad_len  = (rx_byte < MIN_LEN) || (rx_byte > MAX_LEN);
    len_next = frame_length;
    if (len_chk) begin
      len_next = bad_len ? LEN_RESET : rx_byte[INDEX_W-1:0];
    end
    frm_kept = frm_eff && !(len_chk && bad_len);
    bc_inc   = bc_eff + 4'd1;
    done     = frm_kept && (bc_inc == (len_next + 4'd2));
  end

  assign is_byte          = (command == CMD_BYTE);
  assign wr_en            = cmd.accept && is_byte && frm_eff && (32'(bc_eff) < STORE_DEPTH);
  assign last_idx         = frame_length + 4'd1;
  assign status.emit_go   = is_byte && done && !frame_pending;
  assign status.emit_done = (idx == last_idx);
  assign status.out_free  = !result_valid || !result_stall;

  dhfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(bc_eff)),
    .wr_data (rx_byte),
    .rd_addr (AW'(idx)),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte     <= HEADER_RESET;
      in_frame        <= 1'b0;
      one_header_seen <= 1'b0;
      frame_length    <= LEN_RESET;
      byte_count      <= 4'd0;
      frame_pending   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        header_byte <= cfg_data;
      end
      if (cmd.accept) begin
        if (command == CMD_RELEASE) begin
          frame_pending <= 1'b0;
        end else begin
          in_frame        <= frm_kept && !done;
          one_header_seen <= one_next;
          frame_length    <= len_next;
          byte_count      <= frm_eff ? bc_inc : bc_eff;
          if (status.emit_go) begin
            frame_pending <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 4'd0;
    end else if (cmd.accept) begin
      idx <= 4'd0;
    end else if (cmd.next_idx) begin
      idx <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      frame_byte <= (idx == 4'd0) ? header_byte : rd_data;
      byte_index <= idx;
      last       <= status.emit_done;
    end
  end

endmodule

/* hw/rtl/dhfr_checker.sv */
// Port level checker for the frame receiver and its bind statement.
`include "double_header_frame_receiver_assert.svh"

module dhfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_stall,
  input logic       result_valid,
  input logic       result_stall,
  input logic [7:0] frame_byte,
  input logic [3:0] byte_index,
  input logic       last
);

  logic [3:0] expect_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_idx <= 4'd0;
    end else if (result_valid && !result_stall) begin
      expect_idx <= last ? 4'd0 : byte_index + 4'd1;
    end
  end

  property p_result_hold;
    result_valid && result_stall |=>
      result_valid && $stable(frame_byte) && $stable(byte_index) && $stable(last);
  endproperty

  property p_last_range;
    result_valid && last |-> byte_index >= 4'd3 && byte_index <= 4'd9;
  endproperty

  `DHFR_ASSERT_ALWAYS(a_reset_idle, rst |=> !result_valid && !item_stall, "not idle after reset")
  `DHFR_ASSERT(a_result_hold, p_result_hold, "stalled result changed")
  `DHFR_ASSERT(a_index_order, result_valid |-> byte_index == expect_idx, "result out of order")
  `DHFR_ASSERT(a_last_range, p_last_range, "frame end at impossible position")

endmodule

bind double_header_frame_receiver dhfr_checker u_checker (.*);
